### design/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types and constants for the streaming SHA-256 hasher: channel
// payloads, sequencer states, datapath control groups, initial hash values and round constants.
// ----------------------------------------------------------------------------
package shs_pkg;

   // Input transaction payload
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   // Result transaction payload
   typedef struct packed {
      logic [63:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_OUT
   } state_type;

   // Control of the block buffer / message schedule
   typedef struct packed {
      logic       byte_shift;
      logic [7:0] byte_val;
      logic       word_shift;
   } sched_ctrl_type;

   // Control of the round unit and chaining words
   typedef struct packed {
      logic       load;
      logic       round;
      logic       fold;
      logic       init;
      logic [5:0] k_idx;
   } rnd_ctrl_type;

   localparam logic [5:0] SHS_LAST_BYTE  = 6'd63;
   localparam logic [5:0] SHS_LAST_ROUND = 6'd63;
   localparam logic [5:0] SHS_LEN_POS    = 6'd56;
   localparam logic [7:0] SHS_PAD_MARK   = 8'h80;
   localparam logic [1:0] SHS_LAST_WORD  = 2'd3;

   // Initial hash values
   function automatic logic [31:0] shs_init_h(input logic [2:0] idx);
      logic [31:0] val;
      unique case (idx)
         3'd0: val = 32'h6a09e667;
         3'd1: val = 32'hbb67ae85;
         3'd2: val = 32'h3c6ef372;
         3'd3: val = 32'ha54ff53a;
         3'd4: val = 32'h510e527f;
         3'd5: val = 32'h9b05688c;
         3'd6: val = 32'h1f83d9ab;
         3'd7: val = 32'h5be0cd19;
         default: val = 32'h0;
      endcase
      return val;
   endfunction

   // Round constants
   function automatic logic [31:0] shs_round_k(input logic [5:0] idx);
      logic [31:0] val;
      unique case (idx)
         6'd0:  val = 32'h428a2f98;  6'd1:  val = 32'h71374491;
         6'd2:  val = 32'hb5c0fbcf;  6'd3:  val = 32'he9b5dba5;
         6'd4:  val = 32'h3956c25b;  6'd5:  val = 32'h59f111f1;
         6'd6:  val = 32'h923f82a4;  6'd7:  val = 32'hab1c5ed5;
         6'd8:  val = 32'hd807aa98;  6'd9:  val = 32'h12835b01;
         6'd10: val = 32'h243185be;  6'd11: val = 32'h550c7dc3;
         6'd12: val = 32'h72be5d74;  6'd13: val = 32'h80deb1fe;
         6'd14: val = 32'h9bdc06a7;  6'd15: val = 32'hc19bf174;
         6'd16: val = 32'he49b69c1;  6'd17: val = 32'hefbe4786;
         6'd18: val = 32'h0fc19dc6;  6'd19: val = 32'h240ca1cc;
         6'd20: val = 32'h2de92c6f;  6'd21: val = 32'h4a7484aa;
         6'd22: val = 32'h5cb0a9dc;  6'd23: val = 32'h76f988da;
         6'd24: val = 32'h983e5152;  6'd25: val = 32'ha831c66d;
         6'd26: val = 32'hb00327c8;  6'd27: val = 32'hbf597fc7;
         6'd28: val = 32'hc6e00bf3;  6'd29: val = 32'hd5a79147;
         6'd30: val = 32'h06ca6351;  6'd31: val = 32'h14292967;
         6'd32: val = 32'h27b70a85;  6'd33: val = 32'h2e1b2138;
         6'd34: val = 32'h4d2c6dfc;  6'd35: val = 32'h53380d13;
         6'd36: val = 32'h650a7354;  6'd37: val = 32'h766a0abb;
         6'd38: val = 32'h81c2c92e;  6'd39: val = 32'h92722c85;
         6'd40: val = 32'ha2bfe8a1;  6'd41: val = 32'ha81a664b;
         6'd42: val = 32'hc24b8b70;  6'd43: val = 32'hc76c51a3;
         6'd44: val = 32'hd192e819;  6'd45: val = 32'hd6990624;
         6'd46: val = 32'hf40e3585;  6'd47: val = 32'h106aa070;
         6'd48: val = 32'h19a4c116;  6'd49: val = 32'h1e376c08;
         6'd50: val = 32'h2748774c;  6'd51: val = 32'h34b0bcb5;
         6'd52: val = 32'h391c0cb3;  6'd53: val = 32'h4ed8aa4a;
         6'd54: val = 32'h5b9cca4f;  6'd55: val = 32'h682e6ff3;
         6'd56: val = 32'h748f82ee;  6'd57: val = 32'h78a5636f;
         6'd58: val = 32'h84c87814;  6'd59: val = 32'h8cc70208;
         6'd60: val = 32'h90befffa;  6'd61: val = 32'ha4506ceb;
         6'd62: val = 32'hbef9a3f7;  6'd63: val = 32'hc67178f2;
         default: val = 32'h0;
      endcase
      return val;
   endfunction

endpackage

### design/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256 engine: collects message bytes into 64-byte blocks,
// compresses each full block with one shared round unit, pads at end of
// message and returns the digest as four 64-bit big-endian words.
//
//   channel  ports                  payload      direction
//   req      req_valid/req_ready    req_data     in: byte, byte flag, end flag
//   rsp      rsp_valid/rsp_ready    rsp_data     out: digest word, index, last
//
// A byte transaction that does not fill the block leaves the engine idle.
// A full block runs all rounds and then a fold into the chain, during which
// req_ready is low; the round unit runs one round per cycle.
// End of message inserts pad bytes one per cycle (up to 64), runs one or two
// compressions, then holds four rsp transactions; a stalled rsp holds state.
// Synchronous reset restores the initial hash values and clears all counts.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  shs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output shs_pkg::rsp_type rsp_data
);
   import shs_pkg::*;

   state_type        state_ff;
   state_type        state_in;
   logic [5:0]       pend_ff;
   logic [5:0]       pend_in;
   logic [5:0]       rnd_ff;
   logic [5:0]       rnd_in;
   logic [60:0]      count_ff;
   logic [60:0]      count_in;
   logic [1:0]       idx_ff;
   logic [1:0]       idx_in;
   logic             pad_ff;
   logic             pad_in;
   logic             marker_ff;
   logic             marker_in;
   logic             len_ok_ff;
   logic             len_ok_in;
   logic             final_ff;
   logic             final_in;
   logic             acc_req;
   logic             acc_rsp;
   logic             out_done;
   logic [63:0]      bitlen;
   logic [7:0]       len_byte;
   logic [7:0]       pad_byte;
   sched_ctrl_type   sched_ctrl;
   rnd_ctrl_type     rnd_ctrl;
   logic [31:0]      w_cur;
   logic [7:0][31:0] chain;

   assign acc_req  = req_valid && req_ready;
   assign acc_rsp  = rsp_valid && rsp_ready;
   assign out_done = acc_rsp && (idx_ff == SHS_LAST_WORD);

   // Pick the pad byte: marker, zeros, then the big-endian bit length
   assign bitlen   = {count_ff, 3'b000};
   assign len_byte = 8'(bitlen >> {~pend_ff[2:0], 3'b000});
   always_comb begin
      if (!marker_ff) begin
         pad_byte = SHS_PAD_MARK;
      end else if (len_ok_ff && (pend_ff >= SHS_LEN_POS)) begin
         pad_byte = len_byte;
      end else begin
         pad_byte = 8'h00;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc_req) begin
               if (req_data.byte_valid && (pend_ff == SHS_LAST_BYTE)) begin
                  state_in = ST_ROUND;
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            if (rnd_ff == SHS_LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (final_ff) begin
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (pend_ff == SHS_LAST_BYTE) begin
               state_in = ST_ROUND;
            end
         end
         ST_OUT: begin
            if (out_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath controls and handshake outputs
   always_comb begin
      sched_ctrl       = '0;
      rnd_ctrl         = '0;
      rnd_ctrl.k_idx   = rnd_ff;
      req_ready        = 1'b0;
      rsp_valid        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (acc_req && req_data.byte_valid) begin
               sched_ctrl.byte_shift = 1'b1;
               sched_ctrl.byte_val   = req_data.data_byte;
               rnd_ctrl.load         = (pend_ff == SHS_LAST_BYTE);
            end
         end
         ST_ROUND: begin
            rnd_ctrl.round        = 1'b1;
            sched_ctrl.word_shift = 1'b1;
         end
         ST_FOLD: begin
            rnd_ctrl.fold = 1'b1;
         end
         ST_PAD: begin
            sched_ctrl.byte_shift = 1'b1;
            sched_ctrl.byte_val   = pad_byte;
            rnd_ctrl.load         = (pend_ff == SHS_LAST_BYTE);
         end
         ST_OUT: begin
            rsp_valid     = 1'b1;
            rnd_ctrl.init = out_done;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Counters and padding flags
   always_comb begin
      pend_in   = pend_ff;
      rnd_in    = rnd_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pad_in    = pad_ff;
      marker_in = marker_ff;
      len_ok_in = len_ok_ff;
      final_in  = final_ff;

      if (sched_ctrl.byte_shift) begin
         pend_in = pend_ff + 6'd1;
      end
      if (state_ff == ST_ROUND) begin
         rnd_in = rnd_ff + 6'd1;
      end
      if (state_ff == ST_IDLE && acc_req) begin
         if (req_data.byte_valid) begin
            count_in = count_ff + 61'd1;
         end
         if (req_data.end_of_message) begin
            pad_in = 1'b1;
         end
      end
      if (state_ff == ST_PAD) begin
         if (!marker_ff) begin
            marker_in = 1'b1;
            len_ok_in = (pend_ff < SHS_LEN_POS);
         end
         if (pend_ff == SHS_LAST_BYTE) begin
            final_in = marker_ff && len_ok_ff;
         end
      end
      // Length goes into the block after the one holding a late marker
      if (state_ff == ST_FOLD && pad_ff && marker_ff) begin
         len_ok_in = 1'b1;
      end
      if (acc_rsp) begin
         idx_in = idx_ff + 2'd1;
      end
      if (out_done) begin
         count_in  = '0;
         pad_in    = 1'b0;
         marker_in = 1'b0;
         len_ok_in = 1'b0;
         final_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pend_ff   <= '0;
         rnd_ff    <= '0;
         count_ff  <= '0;
         idx_ff    <= '0;
         pad_ff    <= 1'b0;
         marker_ff <= 1'b0;
         len_ok_ff <= 1'b0;
         final_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         rnd_ff    <= rnd_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         pad_ff    <= pad_in;
         marker_ff <= marker_in;
         len_ok_ff <= len_ok_in;
         final_ff  <= final_in;
      end
   end

   shs_msg_sched u_sched (
      .clock (clock),
      .ctrl  (sched_ctrl),
      .w_out (w_cur)
   );

   shs_round_unit u_round (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (rnd_ctrl),
      .w_in      (w_cur),
      .chain_out (chain)
   );

   // Drive the digest word from the held chaining words
   assign rsp_data.digest_word = {chain[{idx_ff, 1'b0}], chain[{idx_ff, 1'b1}]};
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last_word   = (idx_ff == SHS_LAST_WORD);

   // Checks
   a_round_block_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (pend_ff == 6'd0))
      else $error("compression running with partial block");

   a_out_after_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (final_ff && marker_ff && len_ok_ff))
      else $error("digest shown before length block");

   a_fold_after_last_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) |-> ($past(state_ff) == ST_ROUND &&
                                 $past(rnd_ff) == SHS_LAST_ROUND))
      else $error("fold without 64 rounds");

   a_round_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ROUND) |-> (rnd_ff == 6'd0))
      else $error("round counter not at zero outside compression");

   a_out_index_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_OUT) |-> (idx_ff == 2'd0))
      else $error("word index not at zero outside output");

endmodule

### design/shs_msg_sched.sv
// ----------------------------------------------------------------------------
// shs_msg_sched
// 512-bit block buffer that doubles as the 16-word message schedule window.
// Bytes shift in one at a time; during compression the window shifts by one
// word per round and the next schedule word enters at the bottom.
// ----------------------------------------------------------------------------
module shs_msg_sched (
   input  logic                    clock,
   input  shs_pkg::sched_ctrl_type ctrl,
   output logic [31:0]             w_out
);
   import shs_pkg::*;

   logic [511:0] block_ff;
   logic [511:0] block_in;
   logic [31:0]  w0;
   logic [31:0]  w1;
   logic [31:0]  w9;
   logic [31:0]  w14;
   logic [31:0]  sig0;
   logic [31:0]  sig1;
   logic [31:0]  w_new;

   // Pick the schedule taps; word 0 sits at the top of the buffer
   assign w0  = block_ff[511:480];
   assign w1  = block_ff[479:448];
   assign w9  = block_ff[223:192];
   assign w14 = block_ff[63:32];

   // Form the next schedule word
   assign sig0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
   assign sig1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]}
                ^ {10'b0, w14[31:10]};
   assign w_new = w0 + sig0 + w9 + sig1;

   assign w_out = w0;

   // Shift in a byte or advance the window by one word
   always_comb begin
      block_in = block_ff;
      if (ctrl.byte_shift) begin
         block_in = {block_ff[503:0], ctrl.byte_val};
      end else if (ctrl.word_shift) begin
         block_in = {block_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
   end

endmodule

### design/shs_round_unit.sv
// ----------------------------------------------------------------------------
// shs_round_unit
// Working variables, one shared compression round and the eight chaining
// words. The sequencer loads, runs 64 rounds, then folds into the chain.
// ----------------------------------------------------------------------------
module shs_round_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  shs_pkg::rnd_ctrl_type ctrl,
   input  logic [31:0]           w_in,
   output logic [7:0][31:0]      chain_out
);
   import shs_pkg::*;

   logic [7:0][31:0] var_ff;
   logic [7:0][31:0] var_in;
   logic [7:0][31:0] chain_ff;
   logic [7:0][31:0] chain_in;
   logic [31:0]      a_v;
   logic [31:0]      e_v;
   logic [31:0]      big0;
   logic [31:0]      big1;
   logic [31:0]      choose;
   logic [31:0]      major;
   logic [31:0]      tmp1;

   // Round function
   assign a_v    = var_ff[0];
   assign e_v    = var_ff[4];
   assign big1   = {e_v[5:0], e_v[31:6]} ^ {e_v[10:0], e_v[31:11]} ^ {e_v[24:0], e_v[31:25]};
   assign choose = (e_v & var_ff[5]) ^ (~e_v & var_ff[6]);
   assign tmp1   = var_ff[7] + big1 + choose + shs_round_k(ctrl.k_idx) + w_in;
   assign big0   = {a_v[1:0], a_v[31:2]} ^ {a_v[12:0], a_v[31:13]} ^ {a_v[21:0], a_v[31:22]};
   assign major  = (a_v & var_ff[1]) ^ (a_v & var_ff[2]) ^ (var_ff[1] & var_ff[2]);

   // Load from the chain or advance one round
   always_comb begin
      var_in = var_ff;
      if (ctrl.load) begin
         var_in = chain_ff;
      end else if (ctrl.round) begin
         var_in[7] = var_ff[6];
         var_in[6] = var_ff[5];
         var_in[5] = e_v;
         var_in[4] = var_ff[3] + tmp1;
         var_in[3] = var_ff[2];
         var_in[2] = var_ff[1];
         var_in[1] = a_v;
         var_in[0] = tmp1 + big0 + major;
      end
   end

   // Fold the block result into the chain, or return to the initial values
   always_comb begin
      chain_in = chain_ff;
      if (ctrl.init) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = shs_init_h(3'(i));
         end
      end else if (ctrl.fold) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + var_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      var_ff <= var_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= shs_init_h(3'(i));
         end
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign chain_out = chain_ff;

endmodule

### tb/sha256_stream_hasher_tb.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Self-checking testbench for the streaming SHA-256 hasher. A scoreboard
// class keeps its own chaining words, block buffer and byte count, pads and
// compresses each finished message, and queues the four digest words that
// the block must return. Stimulus starts with directed messages, such as the
// empty message, a lone end flag, a single byte and "abc". One long message
// follows that puts the pad marker on the last byte of a block and so needs
// an extra length block. Short random messages follow, with empty items
// mixed in. They run under phases of sender idling and receiver stalling,
// and one phase holds the receiver off long enough that the input backs up.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import shs_pkg::*;

   localparam int unsigned PHASE_ITEMS   = 6;
   localparam int unsigned PHASE_MSGS    = 2;
   localparam int unsigned LONG_MSG_LEN  = 63;
   localparam int unsigned HOLD_OFF_LEN  = 400;
   localparam int unsigned DRAIN_CYCLES  = 200;
   localparam bit [7:0]    PAD_MARK      = 8'h80;
   localparam bit [1:0]    FINAL_INDEX   = 2'd3;

   localparam bit [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam bit [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // Digest predictor and store of expected digest words
   class digest_scoreboard;
      bit [31:0]   chain_h [8];
      bit [7:0]    block_buf [64];
      int unsigned fill_count;
      bit [60:0]   byte_total;
      rsp_type     expected_words [$];
      int unsigned error_count;

      function new();
         error_count = 0;
         restart();
      endfunction

      function void restart();
         foreach (chain_h[i]) chain_h[i] = INIT_H[i];
         fill_count = 0;
         byte_total = '0;
      endfunction

      function bit [31:0] rotr(bit [31:0] x, int unsigned n);
         return (x >> n) | (x << (32 - n));
      endfunction

      // Run the 64 rounds over one block and fold into the chaining words
      function void compress_block(input bit [7:0] blk [64]);
         bit [31:0] sched [64];
         bit [31:0] va, vb, vc, vd, ve, vf, vg, vh;
         bit [31:0] s0, s1, ch, maj, t1, t2;
         for (int t = 0; t < 16; t++)
            sched[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
         for (int t = 16; t < 64; t++) begin
            s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
            s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
            sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
         end
         va = chain_h[0]; vb = chain_h[1]; vc = chain_h[2]; vd = chain_h[3];
         ve = chain_h[4]; vf = chain_h[5]; vg = chain_h[6]; vh = chain_h[7];
         for (int t = 0; t < 64; t++) begin
            s1  = rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25);
            ch  = (ve & vf) ^ (~ve & vg);
            t1  = vh + s1 + ch + ROUND_K[t] + sched[t];
            s0  = rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22);
            maj = (va & vb) ^ (va & vc) ^ (vb & vc);
            t2  = s0 + maj;
            vh = vg; vg = vf; vf = ve; ve = vd + t1;
            vd = vc; vc = vb; vb = va; va = t1 + t2;
         end
         chain_h[0] += va; chain_h[1] += vb; chain_h[2] += vc; chain_h[3] += vd;
         chain_h[4] += ve; chain_h[5] += vf; chain_h[6] += vg; chain_h[7] += vh;
      endfunction

      // Pad the pending bytes, compress, queue four digest words, start over
      function void finish_message();
         bit [7:0]  pad [64];
         bit [63:0] bit_len;
         rsp_type   word;
         for (int i = 0; i < 64; i++)
            pad[i] = (i < fill_count) ? block_buf[i] : 8'h00;
         pad[fill_count] = PAD_MARK;
         if (fill_count + 1 > 56) begin
            compress_block(pad);
            foreach (pad[i]) pad[i] = 8'h00;
         end
         bit_len = {byte_total, 3'b000};
         for (int i = 0; i < 8; i++)
            pad[56 + i] = bit_len[63 - 8*i -: 8];
         compress_block(pad);
         for (int k = 0; k < 4; k++) begin
            word.digest_word    = {chain_h[2*k], chain_h[2*k + 1]};
            word.word_index     = k[1:0];
            word.last_word      = (k[1:0] == FINAL_INDEX);
            expected_words      = {expected_words, word};
         end
         restart();
      endfunction

      // Note one accepted input transaction
      function void note_request(req_type item);
         if (item.byte_valid) begin
            block_buf[fill_count] = item.data_byte;
            byte_total++;
            fill_count++;
            if (fill_count == 64) begin
               compress_block(block_buf);
               fill_count = 0;
            end
         end
         if (item.end_of_message)
            finish_message();
      endfunction

      // Check one accepted result transaction against the oldest expectation
      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected digest word %h index %0d last %0b",
                     $time, got.digest_word, got.word_index, got.last_word);
            error_count++;
            return;
         end
         want = expected_words.pop_front();
         if (got.digest_word !== want.digest_word) begin
            $display("%0t: digest_word expected %h actual %h",
                     $time, want.digest_word, got.digest_word);
            error_count++;
         end
         if (got.word_index !== want.word_index) begin
            $display("%0t: word_index expected %0d actual %0d",
                     $time, want.word_index, got.word_index);
            error_count++;
         end
         if (got.last_word !== want.last_word) begin
            $display("%0t: last_word expected %0b actual %0b",
                     $time, want.last_word, got.last_word);
            error_count++;
         end
      endfunction

      function int unsigned words_waiting();
         return expected_words.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   digest_scoreboard board;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned hold_off_cycles;
   int unsigned sent_items;

   sha256_stream_hasher uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offer one input transaction; return at the falling edge after acceptance
   task automatic send_item(input logic [7:0] data, input bit has_byte, input bit ends);
      req_type item;
      item.data_byte      = data;
      item.byte_valid     = has_byte;
      item.end_of_message = ends;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(item);
      sent_items++;
      @(negedge clock);
   endtask

   // Send one well-formed message with random content and some empty items
   task automatic send_message(input int unsigned msg_len);
      bit split_end;
      split_end = (msg_len == 0) || ($urandom_range(1) == 1);
      for (int i = 0; i < msg_len; i++) begin
         if ($urandom_range(9) == 0)
            send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(255)), 1'b1, !split_end && (i == msg_len - 1));
      end
      if (split_end) begin
         send_item(8'($urandom_range(255)), 1'b0, 1'b1);
      end
   endtask

   function automatic int unsigned pick_length();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 85)
         return $urandom_range(4);
      else
         return $urandom_range(16, 5);
   endfunction

   // Receiver: random stalls, plus a long hold-off counted down here
   initial begin
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Check every result transaction at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_data);
   end

   // Stimulus
   initial begin
      int unsigned msgs;
      int unsigned phase_start;
      board           = new();
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_off_cycles = 0;
      sent_items      = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty message, ignored empty item, single bytes, "abc"
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'ha5, 1'b0, 1'b0);
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h5a, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'hff, 1'b0, 1'b1);

      // Random messages under each idling and stalling phase, then the hold-off phase
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            3: begin send_idle_pct = 38; recv_stall_pct = 38; end
            default: begin
               send_idle_pct   = 0;
               recv_stall_pct  = 0;
               hold_off_cycles = HOLD_OFF_LEN;
            end
         endcase
         msgs        = 0;
         phase_start = sent_items;
         while (sent_items - phase_start < PHASE_ITEMS || msgs < PHASE_MSGS) begin
            if (phase == 0 && msgs == 0)
               send_message(LONG_MSG_LEN);
            else
               send_message(pick_length());
            msgs++;
         end
      end
      req_valid <= 1'b0;

      // Drain the outstanding digest words, then let the block settle
      while (board.words_waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.error_count == 0 && board.words_waiting() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Timeout
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

### filelist.f
design/shs_pkg.sv
design/shs_msg_sched.sv
design/shs_round_unit.sv
design/sha256_stream_hasher.sv
tb/sha256_stream_hasher_tb.sv
